// ----- src/tempo_ratio_classifier_assert.svh -----
// assertion macros shared by the tempo ratio classifier rtl
`ifndef TEMPO_RATIO_CLASSIFIER_ASSERT_SVH
`define TEMPO_RATIO_CLASSIFIER_ASSERT_SVH

// plain implication checked on every edge outside reset
`define TRC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence checked in the cycle after the antecedent
`define TRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/trc_pkg.sv -----
// types, constants and tables of the tempo ratio classifier
package trc_pkg;

  localparam int DVD_W     = 55;  // (hi << 24) dividend
  localparam int DVS_W     = 31;  // positive tempo magnitude
  localparam int DEV_W     = 55;
  localparam int PQ_W      = 7;   // holds up to 127
  localparam int CAND_W    = 31;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEVIATION = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATIO     = 4'd1;

  localparam logic [24:0] MAX_DEV_RESET   = 25'd335544;
  localparam logic [4:0]  MAX_RATIO_RESET = 5'd8;
  localparam logic [24:0] DEV_ONE         = 25'h1000000;
  localparam logic [16:0] STRENGTH_ONE    = 17'h10000;
  localparam int          STR_STEPS       = 20;

  typedef struct packed {
    logic signed [31:0] tempo_a;
    logic signed [31:0] tempo_b;
  } trc_in_t;

  typedef struct packed {
    logic        matched;
    logic        exact;
    logic [14:0] ratio_num;
    logic [14:0] ratio_den;
    logic [24:0] deviation;
    logic [16:0] strength;
  } trc_out_t;

  // row token moving along the cell chain
  typedef struct packed {
    logic             valid;
    logic             have;
    logic [DEV_W-1:0] dev;
    logic [PQ_W-1:0]  p;
    logic [PQ_W-1:0]  q;
  } trc_tok_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLASS, S_DIVR_GO, S_DIVR, S_SEARCH, S_JUDGE, S_STR,
    S_GCD, S_DIVN_GO, S_DIVN, S_DIVD_GO, S_DIVD, S_EMIT
  } trc_state_t;

  // round(2^32 * exp(-200 * 2^k / 2^24))
  localparam logic [31:0] STR_F [STR_STEPS] = '{
    32'd4294916096, 32'd4294864897, 32'd4294762501, 32'd4294557716,
    32'd4294148174, 32'd4293329208, 32'd4291691746, 32'd4288418693,
    32'd4281880076, 32'd4268832733, 32'd4242857198, 32'd4191379343,
    32'd4090289770, 32'd3895366193, 32'd3532943729, 32'd2906120241,
    32'd1966379316, 32'd900274053,  32'd188707693,  32'd8291237
  };

endpackage

// ----- src/trc_div.sv -----
// restoring divider, one quotient bit per cycle
module trc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [trc_pkg::DVD_W-1:0] dividend,
  input  logic [trc_pkg::DVS_W-1:0] divisor,
  output logic                      done,
  output logic [trc_pkg::DVD_W-1:0] quotient
);

  logic [trc_pkg::DVD_W-1:0] dvd_r;
  logic [trc_pkg::DVS_W-1:0] dvs_r;
  logic [trc_pkg::DVS_W-1:0] rem_r;
  logic [5:0]                cnt_r;
  logic                      run_r;
  logic                      done_r;
  logic [trc_pkg::DVS_W:0]   rem_sh;
  logic                      qbit;

  assign rem_sh = {rem_r, dvd_r[trc_pkg::DVD_W-1]};
  assign qbit   = (rem_sh >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 6'(trc_pkg::DVD_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (run_r) begin
      rem_r <= qbit ? trc_pkg::DVS_W'(rem_sh - {1'b0, dvs_r})
                    : trc_pkg::DVS_W'(rem_sh);
      dvd_r <= {dvd_r[trc_pkg::DVD_W-2:0], qbit};
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

// ----- src/trc_cell.sv -----
// one denominator of the search: holds p*2^24/q and refines the row best
module trc_cell #(
  parameter int Q = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  logic                      enable,
  input  logic [trc_pkg::DEV_W-1:0] ratio,
  input  trc_pkg::trc_tok_t         tok_in,
  output trc_pkg::trc_tok_t         tok_out
);

  localparam logic [trc_pkg::CAND_W-1:0] BASE_Q = trc_pkg::CAND_W'((1 << 24) / Q);
  localparam logic [trc_pkg::PQ_W-1:0]   BASE_R = trc_pkg::PQ_W'((1 << 24) % Q);
  localparam logic [trc_pkg::PQ_W-1:0]   QV     = trc_pkg::PQ_W'(Q);

  logic [trc_pkg::CAND_W-1:0] cand_q_r;
  logic [trc_pkg::PQ_W-1:0]   cand_r_r;
  trc_pkg::trc_tok_t          tok_r;
  trc_pkg::trc_tok_t          tok_nxt;
  logic [trc_pkg::PQ_W:0]     r_sum;
  logic [trc_pkg::DEV_W-1:0]  cand_w;
  logic [trc_pkg::DEV_W-1:0]  dev;
  logic                       use_w;

  assign r_sum  = {1'b0, cand_r_r} + {1'b0, BASE_R};
  assign cand_w = trc_pkg::DEV_W'(cand_q_r);
  assign dev    = (ratio >= cand_w) ? ratio - cand_w : cand_w - ratio;
  assign use_w  = tok_in.valid && enable;

  // next row needs (p+1)*2^24/q: add the per-step quotient and carry the remainder
  always_ff @(posedge clk) begin
    if (load) begin
      cand_q_r <= BASE_Q;
      cand_r_r <= BASE_R;
    end else if (use_w) begin
      if (r_sum >= {1'b0, QV}) begin
        cand_q_r <= cand_q_r + BASE_Q + trc_pkg::CAND_W'(1);
        cand_r_r <= trc_pkg::PQ_W'(r_sum - {1'b0, QV});
      end else begin
        cand_q_r <= cand_q_r + BASE_Q;
        cand_r_r <= trc_pkg::PQ_W'(r_sum);
      end
    end
  end

  always_comb begin
    tok_nxt = tok_in;
    if (use_w && (!tok_in.have || dev < tok_in.dev)) begin
      tok_nxt.have = 1'b1;
      tok_nxt.dev  = dev;
      tok_nxt.q    = QV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// ----- src/tempo_ratio_classifier.sv -----
// tempo ratio classifier top level: control, gcd, strength and cell chain
// exact path: classify, binary gcd, then two serial divides for numerator and denominator
// search path: classify, serial ratio divide, the cell chain search over max_ratio rows, then
//   strength when the best deviation is in range (one 32x32 multiply per set dev bit after the first)
// one transaction at a time: busy stays high until the result strobe
// the receiver cannot stall; out_valid is a single-cycle strobe
// synchronous active-low reset returns to idle with reset register values
module tempo_ratio_classifier #(
  parameter int SEARCH_LIMIT = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  trc_pkg::trc_in_t              in_data,
  output logic                          out_valid,
  output trc_pkg::trc_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [trc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trc_pkg::CFG_DAT_W-1:0] cfg_data
);

  `include "tempo_ratio_classifier_assert.svh"

  trc_pkg::trc_state_t state_r, state_nxt;

  logic [24:0]                 max_dev_r;
  logic [4:0]                  max_ratio_r;
  logic [31:0]                 a_r, b_r;
  logic [30:0]                 hi_r, lo_r;
  logic [trc_pkg::DEV_W-1:0]   ratio_r;
  trc_pkg::trc_out_t           res_r;
  trc_pkg::trc_out_t           out_data_r;
  logic                        out_valid_r;
  logic [trc_pkg::PQ_W-1:0]    lim;
  logic [trc_pkg::PQ_W-1:0]    feed_p_r;
  logic [trc_pkg::PQ_W-1:0]    rows_r;
  logic                        best_have_r;
  logic [trc_pkg::DEV_W-1:0]   best_dev_r;
  logic [trc_pkg::PQ_W-1:0]    best_p_r, best_q_r;
  logic [14:0]                 ga_r, gb_r, g_r;
  logic [3:0]                  gk_r;
  logic [32:0]                 s_r;
  logic                        s_one_r;
  logic [63:0]                 prod_r;
  logic                        phase_r;
  logic [4:0]                  k_r;
  logic [19:0]                 sdev_r;
  logic                        accept;
  logic                        bad;
  logic                        whole;
  logic                        div_start;
  logic [trc_pkg::DVD_W-1:0]   div_dvd;
  logic [trc_pkg::DVS_W-1:0]   div_dvs;
  logic                        div_done;
  logic [trc_pkg::DVD_W-1:0]   div_quo;
  logic                        cell_load;
  logic                        tail_last;
  logic [33:0]                 s_round;
  trc_pkg::trc_tok_t           tok [SEARCH_LIMIT+1];

  assign accept    = start && (state_r == trc_pkg::S_IDLE);
  assign busy      = (state_r != trc_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign bad       = (a_r == 32'd0) || (b_r == 32'd0) || a_r[31] || b_r[31];
  assign whole     = (a_r[15:0] == 16'd0) && (b_r[15:0] == 16'd0);
  assign s_round   = {1'b0, s_r} + 34'h8000;

  always_comb begin
    lim = trc_pkg::PQ_W'(max_ratio_r);
    if (lim == '0) lim = trc_pkg::PQ_W'(1);
    if (lim > trc_pkg::PQ_W'(SEARCH_LIMIT)) lim = trc_pkg::PQ_W'(SEARCH_LIMIT);
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dev_r   <= trc_pkg::MAX_DEV_RESET;
      max_ratio_r <= trc_pkg::MAX_RATIO_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        trc_pkg::CFG_MAX_DEVIATION: max_dev_r   <= cfg_data[24:0];
        trc_pkg::CFG_MAX_RATIO:     max_ratio_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // shared divider
  always_comb begin
    div_start = 1'b0;
    div_dvd   = {hi_r, 24'd0};
    div_dvs   = lo_r;
    case (state_r)
      trc_pkg::S_DIVR_GO: div_start = 1'b1;
      trc_pkg::S_DIVN_GO: begin
        div_start = 1'b1;
        div_dvd   = trc_pkg::DVD_W'(hi_r[30:16]);
        div_dvs   = trc_pkg::DVS_W'(g_r);
      end
      trc_pkg::S_DIVD_GO: begin
        div_start = 1'b1;
        div_dvd   = trc_pkg::DVD_W'(lo_r[30:16]);
        div_dvs   = trc_pkg::DVS_W'(g_r);
      end
      default: ;
    endcase
  end

  trc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  // cell chain, one row token per numerator
  assign cell_load = (state_r == trc_pkg::S_DIVR) && div_done;

  always_comb begin
    tok[0]       = '0;
    tok[0].valid = (state_r == trc_pkg::S_SEARCH) && (feed_p_r <= lim);
    tok[0].p     = feed_p_r;
  end

  for (genvar i = 0; i < SEARCH_LIMIT; i++) begin : g_cell
    trc_cell #(.Q(i + 1)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .load    (cell_load),
      .enable  (trc_pkg::PQ_W'(i + 1) <= lim),
      .ratio   (ratio_r),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  assign tail_last = tok[SEARCH_LIMIT].valid && ((rows_r + trc_pkg::PQ_W'(1)) == lim);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= trc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      trc_pkg::S_IDLE:    if (accept) state_nxt = trc_pkg::S_CLASS;
      trc_pkg::S_CLASS: begin
        if (bad)        state_nxt = trc_pkg::S_EMIT;
        else if (whole) state_nxt = trc_pkg::S_GCD;
        else            state_nxt = trc_pkg::S_DIVR_GO;
      end
      trc_pkg::S_DIVR_GO: state_nxt = trc_pkg::S_DIVR;
      trc_pkg::S_DIVR:    if (div_done) state_nxt = trc_pkg::S_SEARCH;
      trc_pkg::S_SEARCH:  if (tail_last) state_nxt = trc_pkg::S_JUDGE;
      trc_pkg::S_JUDGE: begin
        if (best_dev_r > trc_pkg::DEV_W'(max_dev_r))        state_nxt = trc_pkg::S_EMIT;
        else if (best_dev_r >= trc_pkg::DEV_W'(1 << 20)) state_nxt = trc_pkg::S_EMIT;
        else                                             state_nxt = trc_pkg::S_STR;
      end
      trc_pkg::S_STR:     if (k_r == 5'(trc_pkg::STR_STEPS)) state_nxt = trc_pkg::S_EMIT;
      trc_pkg::S_GCD:     if (ga_r == gb_r) state_nxt = trc_pkg::S_DIVN_GO;
      trc_pkg::S_DIVN_GO: state_nxt = trc_pkg::S_DIVN;
      trc_pkg::S_DIVN:    if (div_done) state_nxt = trc_pkg::S_DIVD_GO;
      trc_pkg::S_DIVD_GO: state_nxt = trc_pkg::S_DIVD;
      trc_pkg::S_DIVD:    if (div_done) state_nxt = trc_pkg::S_EMIT;
      trc_pkg::S_EMIT:    state_nxt = trc_pkg::S_IDLE;
      default:            state_nxt = trc_pkg::S_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      trc_pkg::S_IDLE: begin
        a_r <= in_data.tempo_a;
        b_r <= in_data.tempo_b;
      end
      trc_pkg::S_CLASS: begin
        res_r <= '0;
        if (a_r > b_r) begin
          hi_r <= a_r[30:0];
          lo_r <= b_r[30:0];
          ga_r <= a_r[30:16];
          gb_r <= b_r[30:16];
        end else begin
          hi_r <= b_r[30:0];
          lo_r <= a_r[30:0];
          ga_r <= b_r[30:16];
          gb_r <= a_r[30:16];
        end
        gk_r <= '0;
      end
      trc_pkg::S_DIVR: begin
        ratio_r     <= div_quo;
        feed_p_r    <= trc_pkg::PQ_W'(1);
        rows_r      <= '0;
        best_have_r <= 1'b0;
      end
      trc_pkg::S_SEARCH: begin
        if (tok[0].valid) feed_p_r <= feed_p_r + trc_pkg::PQ_W'(1);
        if (tok[SEARCH_LIMIT].valid) begin
          rows_r <= rows_r + trc_pkg::PQ_W'(1);
          // rows arrive in p order, so a strict compare keeps the first minimum
          if (!best_have_r || tok[SEARCH_LIMIT].dev < best_dev_r) begin
            best_have_r <= 1'b1;
            best_dev_r  <= tok[SEARCH_LIMIT].dev;
            best_p_r    <= tok[SEARCH_LIMIT].p;
            best_q_r    <= tok[SEARCH_LIMIT].q;
          end
        end
      end
      trc_pkg::S_JUDGE: begin
        if (best_dev_r <= trc_pkg::DEV_W'(max_dev_r)) begin
          res_r.matched   <= 1'b1;
          res_r.ratio_num <= 15'(best_p_r);
          res_r.ratio_den <= 15'(best_q_r);
          res_r.deviation <= (best_dev_r > trc_pkg::DEV_W'(trc_pkg::DEV_ONE))
                             ? trc_pkg::DEV_ONE : best_dev_r[24:0];
        end
        sdev_r  <= best_dev_r[19:0];
        s_r     <= 33'h100000000;
        s_one_r <= 1'b1;
        phase_r <= 1'b0;
        k_r     <= '0;
      end
      trc_pkg::S_STR: begin
        if (k_r == 5'(trc_pkg::STR_STEPS)) begin
          res_r.strength <= s_round[32:16];
        end else if (!sdev_r[k_r]) begin
          k_r <= k_r + 5'd1;
        end else if (s_one_r) begin
          // multiplying one by the factor rounds back to the factor itself
          s_r     <= {1'b0, trc_pkg::STR_F[k_r]};
          s_one_r <= 1'b0;
          k_r     <= k_r + 5'd1;
        end else if (!phase_r) begin
          prod_r  <= s_r[31:0] * trc_pkg::STR_F[k_r];
          phase_r <= 1'b1;
        end else begin
          s_r     <= {1'b0, 32'((prod_r + 64'h80000000) >> 32)};
          phase_r <= 1'b0;
          k_r     <= k_r + 5'd1;
        end
      end
      trc_pkg::S_GCD: begin
        // binary gcd, one step a cycle
        if (ga_r == gb_r) begin
          g_r <= ga_r << gk_r;
        end else if (!ga_r[0] && !gb_r[0]) begin
          ga_r <= ga_r >> 1;
          gb_r <= gb_r >> 1;
          gk_r <= gk_r + 4'd1;
        end else if (!ga_r[0]) begin
          ga_r <= ga_r >> 1;
        end else if (!gb_r[0]) begin
          gb_r <= gb_r >> 1;
        end else if (ga_r > gb_r) begin
          ga_r <= (ga_r - gb_r) >> 1;
        end else begin
          gb_r <= (gb_r - ga_r) >> 1;
        end
      end
      trc_pkg::S_DIVN: if (div_done) res_r.ratio_num <= div_quo[14:0];
      trc_pkg::S_DIVD: begin
        if (div_done) begin
          res_r.ratio_den <= div_quo[14:0];
          res_r.matched   <= 1'b1;
          res_r.exact     <= 1'b1;
          res_r.deviation <= '0;
          res_r.strength  <= trc_pkg::STRENGTH_ONE;
        end
      end
      trc_pkg::S_EMIT: out_data_r <= res_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == trc_pkg::S_EMIT);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TRC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, busy, "busy not set after accept")
  `TRC_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid, "result strobe too long")
  `TRC_ASSERT(a_exact_full, clk, rst_n, !(out_valid && out_data.exact) || (out_data.matched && out_data.strength == 17'h10000), "exact result without full strength")
  `TRC_ASSERT(a_nomatch_zero, clk, rst_n, !(out_valid && !out_data.matched) || (out_data.ratio_num == 15'd0 && out_data.strength == 17'd0), "unmatched result carries data")

endmodule
